// ===== hdl/prq_pkg.sv =====
// Shared types and codes for the priority ready queue.
// Used by the channel interfaces, the cell row, the slice unit and the top level.
package prq_pkg;

  // Field widths fixed by the item format.
  localparam int unsigned PidW   = 22;
  localparam int unsigned PrioW  = 4;
  localparam int unsigned QuantW = 16;
  localparam int unsigned SliceW = 17;
  localparam int unsigned OccW   = 5;
  localparam int unsigned StatW  = 2;

  // Action codes of an input item.
  localparam logic ACT_ENQUEUE = 1'b0;
  localparam logic ACT_DEQUEUE = 1'b1;

  // Status codes of a result item.
  localparam logic [StatW-1:0] STATUS_OK    = 2'd0;
  localparam logic [StatW-1:0] STATUS_FULL  = 2'd1;
  localparam logic [StatW-1:0] STATUS_EMPTY = 2'd2;

  // Quantum value after reset.
  localparam logic [QuantW-1:0] QUANTUM_RESET = 16'd10;

  // One queue entry.
  typedef struct packed {
    logic [PrioW-1:0] prio;
    logic [PidW-1:0]  pid;
  } entry_t;

  // Control broadcast to every cell of the row.
  typedef struct packed {
    logic   push;
    logic   pop;
    entry_t new_entry;
  } cell_ctrl_t;

  // Contents of the result register.
  typedef struct packed {
    logic [StatW-1:0]  status;
    logic [PidW-1:0]   pid;
    logic [PrioW-1:0]  prio;
    logic [SliceW-1:0] slice;
    logic              slice_valid;
    logic [OccW-1:0]   occupancy;
  } rsp_t;

endpackage

// ===== hdl/prq_req_if.sv =====
// Request channel of the priority ready queue: enqueue or dequeue items.
// Depends on prq_pkg for field widths.
interface prq_req_if;
  logic                        valid;
  logic                        ready;
  logic                        action;
  logic [prq_pkg::PidW-1:0]    pid;
  logic [prq_pkg::PrioW-1:0]   priority_req;

  modport source (output valid, action, pid, priority_req, input ready);
  modport sink   (input valid, action, pid, priority_req, output ready);
endinterface

// ===== hdl/prq_rsp_if.sv =====
// Result channel of the priority ready queue.
// Depends on prq_pkg for field widths.
interface prq_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [prq_pkg::StatW-1:0]    status;
  logic [prq_pkg::PidW-1:0]     out_pid;
  logic [prq_pkg::PrioW-1:0]    out_priority;
  logic [prq_pkg::SliceW-1:0]   slice_len;
  logic                         slice_valid;
  logic [prq_pkg::OccW-1:0]     occupancy;

  modport source (output valid, status, out_pid, out_priority, slice_len, slice_valid,
                  occupancy, input ready);
  modport sink   (input valid, status, out_pid, out_priority, slice_len, slice_valid,
                  occupancy, output ready);
endinterface

// ===== hdl/prq_cfg_if.sv =====
// Configuration write channel carrying the quantum register.
// Depends on prq_pkg for the register width.
interface prq_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [prq_pkg::QuantW-1:0]   quantum;

  modport source (output valid, quantum, input ready);
  modport sink   (input valid, quantum, output ready);
endinterface

// ===== hdl/prq_cell.sv =====
// One cell of the sorted queue row: holds one entry and trades it with its neighbors.
// Depends on prq_pkg for entry and control types.
module prq_cell (
  input  logic                clk_i,
  input  prq_pkg::cell_ctrl_t ctrl_i,
  input  logic                occupied_i,
  input  logic                left_keep_i,
  input  prq_pkg::entry_t     left_entry_i,
  input  prq_pkg::entry_t     right_entry_i,
  output logic                keep_o,
  output prq_pkg::entry_t     entry_o
);

  prq_pkg::entry_t entry_q, entry_d;

  // A held entry stays in place on insert when its priority is at least the new one.
  assign keep_o  = occupied_i && (entry_q.prio >= ctrl_i.new_entry.prio);
  assign entry_o = entry_q;

  // Insert takes the new entry at the boundary and shifts right behind it;
  // pop shifts every entry one place toward the front.
  always_comb begin
    entry_d = entry_q;
    priority if (ctrl_i.push) begin
      if (!keep_o) begin
        entry_d = left_keep_i ? ctrl_i.new_entry : left_entry_i;
      end
    end else if (ctrl_i.pop) begin
      entry_d = right_entry_i;
    end else begin
      entry_d = entry_q;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

// ===== hdl/prq_slice.sv =====
// Time slice unit: scales the quantum by 1, 1.25, 1.5 or 2 for priorities 1 to 4.
// Depends on prq_pkg for widths.
module prq_slice (
  input  logic [prq_pkg::QuantW-1:0] quantum_i,
  input  logic [prq_pkg::PrioW-1:0]  prio_i,
  output logic [prq_pkg::SliceW-1:0] slice_o,
  output logic                       valid_o
);

  logic [prq_pkg::QuantW+2:0] q5;
  logic [prq_pkg::QuantW+1:0] q3;

  // Five and three times the quantum, built from shifts and one add each.
  assign q5 = {3'b000, quantum_i} + {1'b0, quantum_i, 2'b00};
  assign q3 = {2'b00, quantum_i} + {1'b0, quantum_i, 1'b0};

  // Truncating scale by priority; other priorities give no slice.
  always_comb begin
    unique case (prio_i)
      4'd1: begin
        slice_o = {1'b0, quantum_i};
        valid_o = 1'b1;
      end
      4'd2: begin
        slice_o = q5[prq_pkg::QuantW+2:2];
        valid_o = 1'b1;
      end
      4'd3: begin
        slice_o = q3[prq_pkg::QuantW+1:1];
        valid_o = 1'b1;
      end
      4'd4: begin
        slice_o = {quantum_i, 1'b0};
        valid_o = 1'b1;
      end
      default: begin
        slice_o = '0;
        valid_o = 1'b0;
      end
    endcase
  end

endmodule

// ===== hdl/priority_ready_queue.sv =====
// Top level of the stable priority ready queue: cell row, counter and result register.
// Depends on prq_pkg, the three channel interfaces, prq_cell and prq_slice.
//
//   Channel  Dir  Handshake      Payload
//   req_i    in   valid/ready    action, pid, priority_req
//   rsp_o    out  valid/ready    status, out_pid, out_priority, slice_len,
//                                slice_valid, occupancy
//   cfg_i    in   valid/ready    quantum
//
// One item per cycle is accepted unless a stalled result holds it; its result is
// registered in the result register. The cell row allows this rate: every cell
// compares its priority with the new entry in parallel and the row shifts on acceptance.
// Reset clears the entry count and loads the quantum with 10; the cells need no
// clearing pass, since only cells below the count are ever read.
// A stalled result holds the request side until it is taken or taken in the same cycle.
module priority_ready_queue #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  prq_req_if.sink    req_i,
  prq_rsp_if.source  rsp_o,
  prq_cfg_if.sink    cfg_i
);

  localparam int unsigned CntW    = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned CntExtW = (CntW > prq_pkg::OccW) ? CntW : prq_pkg::OccW;

  logic [CntW-1:0]           count_q, count_d;
  logic [prq_pkg::QuantW-1:0] quantum_q;
  logic                      rsp_valid_q;
  prq_pkg::rsp_t             rsp_q, rsp_d;

  logic                      accept;
  logic                      is_full, is_empty;
  prq_pkg::cell_ctrl_t       ctrl;
  logic [CntExtW-1:0]        count_ext;
  logic [prq_pkg::SliceW-1:0] slice;
  logic                      slice_ok;

  logic                      keep    [QUEUE_DEPTH];
  logic                      occupied[QUEUE_DEPTH];
  prq_pkg::entry_t           entry   [QUEUE_DEPTH];

  // Handshakes: requests flow while the result register is free or draining.
  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign cfg_i.ready = 1'b1;
  assign accept      = req_i.valid && req_i.ready;

  assign is_full  = (count_q == CntW'(QUEUE_DEPTH));
  assign is_empty = (count_q == '0);

  // Control broadcast to the row.
  assign ctrl.push           = accept && (req_i.action == prq_pkg::ACT_ENQUEUE) && !is_full;
  assign ctrl.pop            = accept && (req_i.action == prq_pkg::ACT_DEQUEUE) && !is_empty;
  assign ctrl.new_entry.prio = req_i.priority_req;
  assign ctrl.new_entry.pid  = req_i.pid;

  // Row of cells; the front cell sees a kept left neighbor, the last one recycles itself.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    assign occupied[i] = (count_q > CntW'(i));
    if (i == 0) begin : g_front
      prq_cell u_cell (
        .clk_i         (clk_i),
        .ctrl_i        (ctrl),
        .occupied_i    (occupied[i]),
        .left_keep_i   (1'b1),
        .left_entry_i  (entry[i]),
        .right_entry_i (entry[(QUEUE_DEPTH > 1) ? 1 : 0]),
        .keep_o        (keep[i]),
        .entry_o       (entry[i])
      );
    end else if (i == QUEUE_DEPTH - 1) begin : g_back
      prq_cell u_cell (
        .clk_i         (clk_i),
        .ctrl_i        (ctrl),
        .occupied_i    (occupied[i]),
        .left_keep_i   (keep[i-1]),
        .left_entry_i  (entry[i-1]),
        .right_entry_i (entry[i]),
        .keep_o        (keep[i]),
        .entry_o       (entry[i])
      );
    end else begin : g_mid
      prq_cell u_cell (
        .clk_i         (clk_i),
        .ctrl_i        (ctrl),
        .occupied_i    (occupied[i]),
        .left_keep_i   (keep[i-1]),
        .left_entry_i  (entry[i-1]),
        .right_entry_i (entry[i+1]),
        .keep_o        (keep[i]),
        .entry_o       (entry[i])
      );
    end
  end

  // Slice for the entry at the front.
  prq_slice u_slice (
    .quantum_i (quantum_q),
    .prio_i    (entry[0].prio),
    .slice_o   (slice),
    .valid_o   (slice_ok)
  );

  // Entry count after this item.
  always_comb begin
    count_d = count_q;
    priority if (ctrl.push) begin
      count_d = count_q + 1'b1;
    end else if (ctrl.pop) begin
      count_d = count_q - 1'b1;
    end else begin
      count_d = count_q;
    end
  end

  assign count_ext = CntExtW'(count_d);

  // Result of the accepted item.
  always_comb begin
    rsp_d           = '0;
    rsp_d.occupancy = count_ext[prq_pkg::OccW-1:0];
    if (req_i.action == prq_pkg::ACT_ENQUEUE) begin
      rsp_d.status = is_full ? prq_pkg::STATUS_FULL : prq_pkg::STATUS_OK;
    end else if (is_empty) begin
      rsp_d.status = prq_pkg::STATUS_EMPTY;
    end else begin
      rsp_d.status      = prq_pkg::STATUS_OK;
      rsp_d.pid         = entry[0].pid;
      rsp_d.prio        = entry[0].prio;
      rsp_d.slice       = slice;
      rsp_d.slice_valid = slice_ok;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      quantum_q   <= prq_pkg::QUANTUM_RESET;
      rsp_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (cfg_i.valid && cfg_i.ready) begin
        quantum_q <= cfg_i.quantum;
      end
      if (accept) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.status       = rsp_q.status;
  assign rsp_o.out_pid      = rsp_q.pid;
  assign rsp_o.out_priority = rsp_q.prio;
  assign rsp_o.slice_len    = rsp_q.slice;
  assign rsp_o.slice_valid  = rsp_q.slice_valid;
  assign rsp_o.occupancy    = rsp_q.occupancy;

  // The count never passes the number of cells.
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(QUEUE_DEPTH))
    else $error("entry count exceeds queue depth");

  // A successful insert grows the count by exactly one.
  a_push_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.push |=> count_q == $past(count_q) + 1'b1)
    else $error("insert did not advance the entry count");

  // An enqueue into a full queue reports full.
  a_full_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (req_i.action == prq_pkg::ACT_ENQUEUE) && is_full)
      |=> rsp_o.status == prq_pkg::STATUS_FULL)
    else $error("full enqueue not reported");

  // The two front entries stay in priority order.
  a_front_sorted : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q >= CntW'(2)) |-> entry[0].prio >= entry[(QUEUE_DEPTH > 1) ? 1 : 0].prio)
    else $error("front entries out of priority order");

endmodule
